FILE: sv/pidax_pkg.sv
// shared types, constants and helpers for the pid axis controller
package pidax_pkg;

    localparam int GAIN_W    = 24;
    localparam int PER_W     = 16;
    localparam int POS_W     = 16;
    localparam int ERR_W     = POS_W + 1;
    localparam int DIF_W     = ERR_W + 1;
    localparam int INTEG_W   = 24;
    localparam int DRIVE_W   = 13;
    localparam int TIME_W    = 32;
    localparam int CFG_IDX_W = 3;

    localparam int ACC_W     = 64;
    localparam int MPLIER_W  = GAIN_W;
    localparam int MAC_STEPS = MPLIER_W / 2;
    localparam int MAC_CNT_W = $clog2(MAC_STEPS);

    localparam int MS_PER_S  = 1000;
    localparam int THR_W     = PER_W + 10;

    localparam logic signed [INTEG_W-1:0] INTEG_LIMIT     = 24'sd6553600;
    localparam logic signed [DRIVE_W-1:0] DRIVE_LIMIT     = 13'sd2560;
    localparam logic signed [ACC_W-1:0]   DRIVE_LIMIT_Q32 = 64'sd42949672960;

    localparam logic [PER_W-1:0] SAMPLE_TIME_RESET = 16'd1311;
    localparam logic [PER_W-1:0] INV_SAMPLE_RESET  = 16'd1280;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN   = 3'd0,
        CFG_INTEG_GAIN  = 3'd1,
        CFG_DERIV_GAIN  = 3'd2,
        CFG_SAMPLE_TIME = 3'd3,
        CFG_INV_SAMPLE  = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_W_INT,
        ST_INT,
        ST_W_DIF,
        ST_L_KD,
        ST_W_KD,
        ST_L_KP,
        ST_W_KP,
        ST_L_KI,
        ST_W_KI,
        ST_CLAMP,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic signed [GAIN_W-1:0] prop_gain;
        logic signed [GAIN_W-1:0] integ_gain;
        logic signed [GAIN_W-1:0] deriv_gain;
        logic        [PER_W-1:0]  sample_time;
        logic        [PER_W-1:0]  inv_sample_time;
    } t_cfg;

    typedef struct packed {
        logic                start;
        logic                clear;
        logic [ACC_W-1:0]    mcand;
        logic [MPLIER_W-1:0] mplier;
    } t_mac_req;

    typedef struct packed {
        logic             done;
        logic [ACC_W-1:0] acc;
    } t_mac_rsp;

    typedef struct packed {
        logic nz;
        logic dbl;
        logic neg;
    } t_booth;

    // radix-4 booth recoding of {b[1], b[0], b[-1]}
    function automatic t_booth booth_decode(input logic [2:0] bits);
        t_booth d;
        d = '0;
        unique case (bits)
            3'b000, 3'b111: d = '0;
            3'b001, 3'b010: d.nz = 1'b1;
            3'b011: begin
                d.nz  = 1'b1;
                d.dbl = 1'b1;
            end
            3'b100: begin
                d.nz  = 1'b1;
                d.dbl = 1'b1;
                d.neg = 1'b1;
            end
            3'b101, 3'b110: begin
                d.nz  = 1'b1;
                d.neg = 1'b1;
            end
            default: d = '0;
        endcase
        return d;
    endfunction

endpackage

FILE: sv/pidax_mac.sv
// digit-serial multiply-accumulate unit, two multiplier bits per cycle
module pidax_mac
    import pidax_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mac_req i_req,
    output t_mac_rsp o_rsp
);

    logic                 r_busy;
    logic [MAC_CNT_W-1:0] r_cnt;
    logic [ACC_W-1:0]     r_m;
    logic [MPLIER_W-1:0]  r_q;
    logic                 r_qm;
    logic [ACC_W-1:0]     r_acc;
    logic [ACC_W-1:0]     n_acc;
    logic                 last_step;
    t_booth               digit;
    logic [ACC_W-1:0]     pp;
    logic [ACC_W-1:0]     addend;

    assign last_step = r_busy && (r_cnt == MAC_CNT_W'(MAC_STEPS - 1));

    always_comb begin
        digit  = booth_decode({r_q[1:0], r_qm});
        pp     = digit.dbl ? (r_m << 1) : r_m;
        if (!digit.nz) begin
            pp = '0;
        end
        addend = digit.neg ? ~pp : pp;
        n_acc  = r_acc + addend + ACC_W'(digit.neg);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (last_step) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_m  <= i_req.mcand;
            r_q  <= i_req.mplier;
            r_qm <= 1'b0;
            if (i_req.clear) begin
                r_acc <= '0;
            end
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_m   <= r_m << 2;
            r_q   <= {{2{r_q[MPLIER_W-1]}}, r_q[MPLIER_W-1:2]};
            r_qm  <= r_q[1];
        end
    end

    assign o_rsp.done = last_step;
    assign o_rsp.acc  = r_acc;

endmodule

FILE: sv/pidax_seq.sv
// control sequencer, loop state and output register of the pid controller
module pidax_seq
    import pidax_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cfg                      i_cfg,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [TIME_W-1:0]         i_now_ms,
    input  logic signed [POS_W-1:0]   i_measured_pos,
    input  logic signed [POS_W-1:0]   i_target_pos,
    output t_mac_req                  o_mac_req,
    input  t_mac_rsp                  i_mac_rsp,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [DRIVE_W-1:0] o_drive,
    output logic                      o_updated
);

    t_state r_state;
    t_state n_state;

    logic [TIME_W-1:0]         r_now;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [INTEG_W-1:0] r_integral;
    logic signed [ERR_W-1:0]   r_prev_err;
    logic signed [DRIVE_W-1:0] r_held;
    logic [TIME_W-1:0]         r_last_ms;
    logic                      r_updated;
    logic                      r_out_valid;
    logic signed [DRIVE_W-1:0] r_out_drive;
    logic                      r_out_updated;

    logic                        accept;
    logic                        out_free;
    logic signed [ERR_W-1:0]     in_err;
    logic [TIME_W-1:0]           elapsed;
    logic [THR_W-1:0]            threshold;
    logic                        due;
    logic signed [DIF_W-1:0]     dif;
    logic signed [INTEG_W+1:0]   int_step;
    logic signed [INTEG_W+2:0]   int_sum;
    logic signed [INTEG_W-1:0]   n_integral;
    logic signed [ACC_W-1:0]     acc;
    logic signed [DRIVE_W-1:0]   n_held;

    assign accept   = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign in_err   = ERR_W'(i_target_pos) - ERR_W'(i_measured_pos);
    assign acc      = $signed(i_mac_rsp.acc);

    // due when elapsed * 2^16 reaches sample_time * 1000
    always_comb begin
        elapsed   = r_now - r_last_ms;
        threshold = THR_W'(i_cfg.sample_time) * THR_W'(MS_PER_S);
        due       = (|elapsed[TIME_W-1:THR_W-PER_W])
                    || ({elapsed[THR_W-PER_W-1:0], {PER_W{1'b0}}} >= threshold);
    end

    always_comb begin
        dif      = DIF_W'(r_err) - DIF_W'(r_prev_err);
        int_step = $signed(i_mac_rsp.acc[INTEG_W+9:8]);
        int_sum  = (INTEG_W + 3)'(r_integral) + (INTEG_W + 3)'(int_step);
        priority if (int_sum > (INTEG_W + 3)'(INTEG_LIMIT)) begin
            n_integral = INTEG_LIMIT;
        end else if (int_sum < -(INTEG_W + 3)'(INTEG_LIMIT)) begin
            n_integral = -INTEG_LIMIT;
        end else begin
            n_integral = int_sum[INTEG_W-1:0];
        end
    end

    always_comb begin
        priority if (acc > DRIVE_LIMIT_Q32) begin
            n_held = DRIVE_LIMIT;
        end else if (acc < -DRIVE_LIMIT_Q32) begin
            n_held = -DRIVE_LIMIT;
        end else begin
            n_held = acc[DRIVE_W+23:24];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_CHECK;
            ST_CHECK: n_state = due ? ST_W_INT : ST_OUT;
            ST_W_INT: if (i_mac_rsp.done) n_state = ST_INT;
            ST_INT:   n_state = ST_W_DIF;
            ST_W_DIF: if (i_mac_rsp.done) n_state = ST_L_KD;
            ST_L_KD:  n_state = ST_W_KD;
            ST_W_KD:  if (i_mac_rsp.done) n_state = ST_L_KP;
            ST_L_KP:  n_state = ST_W_KP;
            ST_W_KP:  if (i_mac_rsp.done) n_state = ST_L_KI;
            ST_L_KI:  n_state = ST_W_KI;
            ST_W_KI:  if (i_mac_rsp.done) n_state = ST_CLAMP;
            ST_CLAMP: n_state = ST_OUT;
            ST_OUT:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        o_mac_req  = '0;
        unique case (r_state)
            ST_CHECK: begin
                o_mac_req.start  = due;
                o_mac_req.clear  = 1'b1;
                o_mac_req.mcand  = ACC_W'(r_err);
                o_mac_req.mplier = MPLIER_W'(i_cfg.sample_time);
            end
            ST_INT: begin
                o_mac_req.start  = 1'b1;
                o_mac_req.clear  = 1'b1;
                o_mac_req.mcand  = ACC_W'(dif);
                o_mac_req.mplier = MPLIER_W'(i_cfg.inv_sample_time);
            end
            ST_L_KD: begin
                o_mac_req.start  = 1'b1;
                o_mac_req.clear  = 1'b1;
                o_mac_req.mcand  = ACC_W'($signed(i_mac_rsp.acc[DIF_W+PER_W-1:0])) << 2;
                o_mac_req.mplier = i_cfg.deriv_gain;
            end
            ST_L_KP: begin
                o_mac_req.start  = 1'b1;
                o_mac_req.mcand  = ACC_W'(r_err) << 8;
                o_mac_req.mplier = i_cfg.prop_gain;
            end
            ST_L_KI: begin
                o_mac_req.start  = 1'b1;
                o_mac_req.mcand  = ACC_W'(r_integral);
                o_mac_req.mplier = i_cfg.integ_gain;
            end
            default: o_mac_req = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_integral  <= '0;
            r_prev_err  <= '0;
            r_held      <= '0;
            r_last_ms   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_CHECK) && due) begin
                r_last_ms <= r_now;
            end
            if (r_state == ST_INT) begin
                r_integral <= n_integral;
            end
            if (r_state == ST_CLAMP) begin
                r_held     <= n_held;
                r_prev_err <= r_err;
            end
            if ((r_state == ST_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_now <= i_now_ms;
            r_err <= in_err;
        end
        if (r_state == ST_CHECK) begin
            r_updated <= due;
        end
        if ((r_state == ST_OUT) && out_free) begin
            r_out_drive   <= r_held;
            r_out_updated <= r_updated;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_drive     = r_out_drive;
    assign o_updated   = r_out_updated;

endmodule

FILE: sv/pid_axis_controller.sv
// single-axis pid controller with clamped integral, top level
//
// input channel: i_in_valid / o_in_stall carries a time stamp in ms, a
// measured and a target position (Q8.8). output channel: o_out_valid /
// i_out_stall carries one item per input: the drive (Q5.8, within +-10)
// and an updated flag. the user writes gains and sample periods through
// i_cfg_we / i_cfg_index / i_cfg_data only while the block is idle;
// the block itself does not enforce this. a not-yet-due item goes from
// accept through the check and output states to the output register.
// a due item runs five products through one radix-4 digit-serial
// multiply-accumulate unit, plus the integral and clamp steps.
// one item is in flight at a time; the next is accepted once the result
// sits in the output register, which holds it while the receiver stalls.
// reset (synchronous, active low) clears the integral, previous error,
// held drive and last update time and loads the default configuration.
module pid_axis_controller
    import pidax_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [GAIN_W-1:0]         i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [TIME_W-1:0]         i_now_ms,
    input  logic signed [POS_W-1:0]   i_measured_pos,
    input  logic signed [POS_W-1:0]   i_target_pos,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [DRIVE_W-1:0] o_drive,
    output logic                      o_updated
);

    t_cfg     r_cfg;
    t_mac_req mac_req;
    t_mac_rsp mac_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain       <= '0;
            r_cfg.integ_gain      <= '0;
            r_cfg.deriv_gain      <= '0;
            r_cfg.sample_time     <= SAMPLE_TIME_RESET;
            r_cfg.inv_sample_time <= INV_SAMPLE_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PROP_GAIN:   r_cfg.prop_gain       <= i_cfg_data;
                CFG_INTEG_GAIN:  r_cfg.integ_gain      <= i_cfg_data;
                CFG_DERIV_GAIN:  r_cfg.deriv_gain      <= i_cfg_data;
                CFG_SAMPLE_TIME: r_cfg.sample_time     <= i_cfg_data[PER_W-1:0];
                CFG_INV_SAMPLE:  r_cfg.inv_sample_time <= i_cfg_data[PER_W-1:0];
                default: ;
            endcase
        end
    end

    pidax_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_now_ms       (i_now_ms),
        .i_measured_pos (i_measured_pos),
        .i_target_pos   (i_target_pos),
        .o_mac_req      (mac_req),
        .i_mac_rsp      (mac_rsp),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_drive        (o_drive),
        .o_updated      (o_updated)
    );

    pidax_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mac_req),
        .o_rsp   (mac_rsp)
    );

endmodule

FILE: sv/pidax_checker.sv
// port-level checks for the pid axis controller, bound to the top level
module pidax_checker
    import pidax_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic signed [DRIVE_W-1:0] o_drive,
    input logic                      o_updated
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_drive) && $stable(o_updated))
        else $error("stalled result changed");

    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_drive <= DRIVE_LIMIT) && (o_drive >= -DRIVE_LIMIT))
        else $error("drive outside clamp range");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item accepted while busy");

    a_result_after_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without an item in flight");

endmodule

bind pid_axis_controller pidax_checker u_pidax_checker (.*);
